// File: src/iir_direct_form_filter_macros.svh
// Assertion macros shared by the filter modules.
`ifndef IIR_DIRECT_FORM_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_FILTER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define IIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define IIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/iir_dff_pkg.sv
// Shared types and constants for the direct form I IIR filter.
package iir_dff_pkg;

    localparam int COEF_BITS   = 18;
    localparam int ORDER_BITS  = 3;
    localparam int NUM_TAPS    = 4;
    localparam int TAP_W       = 2;
    localparam int REG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;

    typedef logic [2:0]                   reg_idx_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef logic [ORDER_BITS-1:0]        order_t;

    localparam reg_idx_t REG_ORDER = 3'd0;
    localparam reg_idx_t REG_FF0   = 3'd1;
    localparam reg_idx_t REG_FF1   = 3'd2;
    localparam reg_idx_t REG_FF2   = 3'd3;
    localparam reg_idx_t REG_FF3   = 3'd4;
    localparam reg_idx_t REG_FB1   = 3'd5;
    localparam reg_idx_t REG_FB2   = 3'd6;
    localparam reg_idx_t REG_FB3   = 3'd7;

    localparam order_t ORDER_RESET = 3'd1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MAC    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic sub;
    } mac_ctrl_t;

endpackage

// File: src/iir_dff_regs.sv
// APB register file: filter order and feedforward/feedback coefficients.
module iir_dff_regs #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [iir_dff_pkg::REG_ADDR_W-1:0]    paddr,
    input  logic [iir_dff_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [iir_dff_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                  pready,
    output iir_dff_pkg::order_t                   order,
    output logic                                  order_wr,
    output iir_dff_pkg::coef_t                    ff_coeff [iir_dff_pkg::NUM_TAPS],
    output iir_dff_pkg::coef_t                    fb_coeff [iir_dff_pkg::NUM_TAPS]
);

    localparam iir_dff_pkg::coef_t FF0_RESET =
        iir_dff_pkg::coef_t'(iir_dff_pkg::COEF_BITS'(1) << COEF_FRAC_BITS);

    iir_dff_pkg::order_t   order_reg;
    iir_dff_pkg::coef_t    ff_reg [iir_dff_pkg::NUM_TAPS];
    iir_dff_pkg::coef_t    fb_reg [iir_dff_pkg::NUM_TAPS];
    iir_dff_pkg::reg_idx_t idx;
    logic                  wr;

    assign pready   = 1'b1;
    assign idx      = paddr[iir_dff_pkg::REG_ADDR_W-1:2];
    assign wr       = psel && penable && pwrite && pready;
    assign order_wr = wr && (idx == iir_dff_pkg::REG_ORDER);
    assign order    = order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= iir_dff_pkg::ORDER_RESET;
            for (int i = 0; i < iir_dff_pkg::NUM_TAPS; i++)
            begin
                ff_reg[i] <= '0;
                fb_reg[i] <= '0;
            end
            ff_reg[0] <= FF0_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                iir_dff_pkg::REG_ORDER:
                    order_reg <= pwdata[iir_dff_pkg::ORDER_BITS-1:0];
                iir_dff_pkg::REG_FF0, iir_dff_pkg::REG_FF1,
                iir_dff_pkg::REG_FF2, iir_dff_pkg::REG_FF3:
                    ff_reg[iir_dff_pkg::TAP_W'(idx - iir_dff_pkg::REG_FF0)] <=
                        pwdata[iir_dff_pkg::COEF_BITS-1:0];
                iir_dff_pkg::REG_FB1, iir_dff_pkg::REG_FB2, iir_dff_pkg::REG_FB3:
                    fb_reg[iir_dff_pkg::TAP_W'(idx - iir_dff_pkg::REG_FB1 + 3'd1)] <=
                        pwdata[iir_dff_pkg::COEF_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < iir_dff_pkg::NUM_TAPS; i++)
        begin
            ff_coeff[i] = ff_reg[i];
            fb_coeff[i] = fb_reg[i];
        end
    end

    always_comb
    begin
        unique case (idx)
            iir_dff_pkg::REG_ORDER:
                prdata = iir_dff_pkg::CFG_DATA_W'(order_reg);
            iir_dff_pkg::REG_FF0, iir_dff_pkg::REG_FF1,
            iir_dff_pkg::REG_FF2, iir_dff_pkg::REG_FF3:
                prdata = iir_dff_pkg::CFG_DATA_W'(
                    ff_reg[iir_dff_pkg::TAP_W'(idx - iir_dff_pkg::REG_FF0)]);
            iir_dff_pkg::REG_FB1, iir_dff_pkg::REG_FB2, iir_dff_pkg::REG_FB3:
                prdata = iir_dff_pkg::CFG_DATA_W'(
                    fb_reg[iir_dff_pkg::TAP_W'(idx - iir_dff_pkg::REG_FB1 + 3'd1)]);
        endcase
    end

endmodule

// File: src/iir_dff_hist.sv
// History memory: one entry per past sample holding {x, y}, with per-entry valid bits.
`include "iir_direct_form_filter_macros.svh"

module iir_dff_hist #(
    parameter int SAMPLE_BITS = 16,
    parameter int PTR_W       = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          wr_en,
    input  logic [PTR_W-1:0]              wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_x,
    input  logic signed [SAMPLE_BITS-1:0] wr_y,
    input  logic [PTR_W-1:0]              rd_addr,
    output logic signed [SAMPLE_BITS-1:0] rd_x,
    output logic signed [SAMPLE_BITS-1:0] rd_y
);

    localparam int DEPTH = 2 ** PTR_W;

    logic [2*SAMPLE_BITS-1:0] mem [DEPTH];
    logic [2*SAMPLE_BITS-1:0] rd_data_reg;
    logic                     rd_valid_reg;
    logic [DEPTH-1:0]         valid_reg;
    logic [DEPTH-1:0]         valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // never-written entries read as zero history
    assign rd_x = rd_valid_reg ? rd_data_reg[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    assign rd_y = rd_valid_reg ? rd_data_reg[SAMPLE_BITS-1:0] : '0;

    `IIR_ASSERT_NEXT(a_clear_empties, clear, valid_reg == '0, "history not cleared")

endmodule

// File: src/iir_dff_mac.sv
// Shared multiply-accumulate unit with rounding and saturation to the sample width.
`include "iir_direct_form_filter_macros.svh"

module iir_dff_mac #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iir_dff_pkg::mac_ctrl_t        ctrl,
    input  iir_dff_pkg::coef_t            coef,
    input  logic signed [SAMPLE_BITS-1:0] data,
    output logic [SAMPLE_BITS-1:0]        y
);

    localparam int PROD_W = SAMPLE_BITS + iir_dff_pkg::COEF_BITS;
    localparam int ACC_W  = PROD_W + 4;
    localparam int HI_W   = ACC_W - SAMPLE_BITS + 1;
    localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     sub_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shifted;
    logic [HI_W-1:0]          hi;

    assign prod_next = PROD_W'(coef) * PROD_W'(data);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
            sub_reg  <= ctrl.sub;
        end
    end

    always_comb
    begin
        priority if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = sub_reg ? acc_reg - ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
            acc_reg      <= acc_next;
        end
    end

    // round half up, floor, then clamp to the sample range
    assign rnd     = acc_reg + signed'(HALF_LSB);
    assign shifted = rnd >>> COEF_FRAC_BITS;
    assign hi      = shifted[ACC_W-1:SAMPLE_BITS-1];

    always_comb
    begin
        priority if ((&hi) || !(|hi))
        begin
            y = shifted[SAMPLE_BITS-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    `IIR_ASSERT_NEXT(a_clr_zeroes_acc, ctrl.clr, acc_reg == '0, "accumulator not cleared")

endmodule

// File: src/iir_direct_form_filter.sv
// Top level: sequencer for the direct form I IIR filter around a shared MAC and history memory.
//
//  channel | dir | handshake                 | payload
//  s_*     | in  | s_tvalid / s_tready       | s_tdata: sample_in
//  m_*     | out | m_tvalid / m_tready       | m_tdata: sample_out
//  apb     | in  | psel & penable & pwrite   | paddr, pwdata, prdata (pready tied high)
//
// A sample runs through ST_MAC, ST_DRAIN and ST_FINISH before the next is accepted; the single
// multiplier does one product per cycle, two per feedback/feedforward tap pair plus one.
// Reset: histories read as zero, order = 1, ff_coeff_0 = 1.0, other coefficients zero.
// An order write clears both histories. The result register frees the input side; the
// sequencer waits only when a finished result finds the previous one still not taken.
`include "iir_direct_form_filter_macros.svh"

module iir_direct_form_filter #(
    parameter int  MAX_ORDER      = 4,
    parameter int  SAMPLE_BITS    = 16,
    parameter int  COEF_FRAC_BITS = 14,
    localparam int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [iir_dff_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [iir_dff_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [iir_dff_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [DATA_W-1:0]                    s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [DATA_W-1:0]                    m_tdata    // [SAMPLE_BITS-1:0] sample_out
);

    localparam int PTR_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int STEP_W = $clog2(2 * MAX_ORDER);

    iir_dff_pkg::state_t    state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [STEP_W-1:0]      last_reg, last_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [SAMPLE_BITS-1:0] out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    iir_dff_pkg::order_t    order;
    iir_dff_pkg::order_t    taps;
    logic                   order_wr;
    iir_dff_pkg::coef_t     ff_coeff [iir_dff_pkg::NUM_TAPS];
    iir_dff_pkg::coef_t     fb_coeff [iir_dff_pkg::NUM_TAPS];

    logic                   accept;
    logic                   fin_go;
    logic [STEP_W:0]        step_inc;
    logic [iir_dff_pkg::TAP_W-1:0] tap;
    logic [PTR_W-1:0]       rd_addr;
    logic signed [SAMPLE_BITS-1:0] hist_x;
    logic signed [SAMPLE_BITS-1:0] hist_y;
    iir_dff_pkg::mac_ctrl_t mac_ctrl;
    iir_dff_pkg::coef_t     mac_coef;
    logic signed [SAMPLE_BITS-1:0] mac_data;
    logic [SAMPLE_BITS-1:0] y;

    iir_dff_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .order    (order),
        .order_wr (order_wr),
        .ff_coeff (ff_coeff),
        .fb_coeff (fb_coeff)
    );

    iir_dff_hist #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PTR_W       (PTR_W)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (order_wr),
        .wr_en   (fin_go),
        .wr_addr (ptr_reg),
        .wr_x    (x_reg),
        .wr_y    (y),
        .rd_addr (rd_addr),
        .rd_x    (hist_x),
        .rd_y    (hist_y)
    );

    iir_dff_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .coef  (mac_coef),
        .data  (mac_data),
        .y     (y)
    );

    assign s_tready = (state_reg == iir_dff_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fin_go   = (state_reg == iir_dff_pkg::ST_FINISH) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_reg);

    // order 0 acts as 1, above MAX_ORDER saturates
    always_comb
    begin
        priority if (order == '0)
        begin
            taps = iir_dff_pkg::order_t'(1);
        end
        else if (order > iir_dff_pkg::order_t'(MAX_ORDER))
        begin
            taps = iir_dff_pkg::order_t'(MAX_ORDER);
        end
        else
        begin
            taps = order;
        end
    end

    // step j: 0 -> ff0*x, odd -> ff[tap]*x[n-tap], even -> -fb[tap]*y[n-tap]
    assign step_inc = {1'b0, step_reg} + 1'b1;
    assign tap      = iir_dff_pkg::TAP_W'(step_inc >> 1);
    // read one step ahead; registered data lines up with the odd and even step of a tap
    assign rd_addr  = ptr_reg - PTR_W'(1) - PTR_W'(step_reg >> 1);

    always_comb
    begin
        mac_ctrl.clr    = accept;
        mac_ctrl.mul_en = (state_reg == iir_dff_pkg::ST_MAC);
        mac_ctrl.sub    = (step_reg != '0) && !step_reg[0];
        priority if (step_reg == '0)
        begin
            mac_coef = ff_coeff[0];
            mac_data = x_reg;
        end
        else if (step_reg[0])
        begin
            mac_coef = ff_coeff[tap];
            mac_data = hist_x;
        end
        else
        begin
            mac_coef = fb_coeff[tap];
            mac_data = hist_y;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        ptr_next       = ptr_reg;
        x_next         = x_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            iir_dff_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    x_next     = s_tdata[SAMPLE_BITS-1:0];
                    step_next  = '0;
                    last_next  = STEP_W'({taps - 3'd1, 1'b0});
                    state_next = iir_dff_pkg::ST_MAC;
                end
            end
            iir_dff_pkg::ST_MAC:
            begin
                if (step_reg == last_reg)
                begin
                    state_next = iir_dff_pkg::ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            iir_dff_pkg::ST_DRAIN:
            begin
                state_next = iir_dff_pkg::ST_FINISH;
            end
            iir_dff_pkg::ST_FINISH:
            begin
                if (fin_go)
                begin
                    out_next       = y;
                    out_valid_next = 1'b1;
                    ptr_next       = ptr_reg + 1'b1;
                    state_next     = iir_dff_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iir_dff_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iir_dff_pkg::ST_IDLE;
            step_reg      <= '0;
            last_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        out_reg <= out_next;
    end

    `IIR_ASSERT_NOW(a_step_bound, state_reg == iir_dff_pkg::ST_MAC, step_reg <= last_reg, "step past last tap")
    `IIR_ASSERT_NEXT(a_ptr_advance, fin_go, ptr_reg == PTR_W'($past(ptr_reg) + 1'b1), "pointer did not advance")
    `IIR_ASSERT_NEXT(a_result_shown, fin_go, m_tvalid && s_tready, "result not presented after finish")

endmodule
